// ----- rtl/bpmc_pkg.sv -----
// shared types, mode codes and register indexes for the battery pack mode controller
`timescale 1ns / 1ps

package bpmc_pkg;

	localparam int DWELL_W = 12;
	localparam int MODE_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int INIT_TICKS_DEF = 15;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_INIT      = 4'd0;
	localparam logic [MODE_W-1:0] MODE_IDLE      = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PRECHARGE = 4'd2;
	localparam logic [MODE_W-1:0] MODE_RUN       = 4'd3;
	localparam logic [MODE_W-1:0] MODE_STOP      = 4'd4;
	localparam logic [MODE_W-1:0] MODE_SLEEP     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_NFAULT    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_SFAULT    = 4'd7;
	localparam logic [MODE_W-1:0] MODE_CHARGING  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_CHARGED   = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEV_VOLT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEV_CURR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEV_TEMP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NRM_VOLT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NRM_CURR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NRM_TEMP   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLT  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRECH_TICK = 3'd7;

	// configuration reset values
	localparam logic [15:0] SEV_VOLT_RST   = 16'd65535;
	localparam logic [15:0] SEV_CURR_RST   = 16'd32767;
	localparam logic [7:0]  SEV_TEMP_RST   = 8'd127;
	localparam logic [15:0] NRM_VOLT_RST   = 16'd65535;
	localparam logic [15:0] NRM_CURR_RST   = 16'd32767;
	localparam logic [7:0]  NRM_TEMP_RST   = 8'd127;
	localparam logic [15:0] FULL_VOLT_RST  = 16'd51600;
	localparam logic [DWELL_W-1:0] PRECH_TICK_RST = 12'd15;

	typedef struct packed {
		logic               start_req;
		logic               charge_req;
		logic               stop_req;
		logic               reset_req;
		logic        [15:0] pack_voltage_mv;
		logic signed [15:0] pack_current_ma;
		logic signed [7:0]  pack_temp_c;
	} in_item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              contactor_on;
		logic              mode_changed;
	} out_item_t;

	typedef struct packed {
		logic        [15:0] volt;
		logic signed [15:0] curr;
		logic signed [7:0]  temp;
	} limits_t;

	typedef struct packed {
		logic severe;
		logic normal;
	} fault_t;

endpackage

// ----- rtl/bpmc_fault_chk.sv -----
// compares one set of pack measurements against the severe and normal limits
`timescale 1ns / 1ps

module bpmc_fault_chk
	import bpmc_pkg::*;
(
	input  in_item_t item,
	input  limits_t  severe_lim,
	input  limits_t  normal_lim,
	output fault_t   fault
);

	always_comb begin
		fault.severe = (item.pack_voltage_mv > severe_lim.volt)
			|| ($signed(item.pack_current_ma) > $signed(severe_lim.curr))
			|| ($signed(item.pack_temp_c) > $signed(severe_lim.temp));
		fault.normal = (item.pack_voltage_mv > normal_lim.volt)
			|| ($signed(item.pack_current_ma) > $signed(normal_lim.curr))
			|| ($signed(item.pack_temp_c) > $signed(normal_lim.temp));
	end

endmodule

// ----- rtl/bpmc_mode_step.sv -----
// next mode, contactor drive and dwell count for one control tick
`timescale 1ns / 1ps

module bpmc_mode_step
	import bpmc_pkg::*;
#(
	parameter int INIT_TICKS = INIT_TICKS_DEF
) (
	input  logic [MODE_W-1:0]  mode_prev,
	input  logic               contactor_prev,
	input  logic [DWELL_W-1:0] dwell_prev,
	input  in_item_t           item,
	input  fault_t             fault,
	input  logic [15:0]        full_charge_voltage,
	input  logic [DWELL_W-1:0] precharge_ticks,
	output logic [MODE_W-1:0]  mode_next,
	output logic               contactor_next,
	output logic [DWELL_W-1:0] dwell_next
);

	localparam logic [DWELL_W-1:0] INIT_LIMIT = DWELL_W'(INIT_TICKS);

	logic [DWELL_W:0]   cnt;
	logic [DWELL_W-1:0] limit;
	logic [DWELL_W-1:0] dwell_keep;
	logic [MODE_W-1:0]  stepped;

	assign cnt   = {1'b0, dwell_prev} + {{DWELL_W{1'b0}}, 1'b1};
	assign limit = (mode_prev == MODE_INIT) ? INIT_LIMIT : precharge_ticks;

	always_comb begin
		stepped        = mode_prev;
		contactor_next = contactor_prev;
		dwell_keep     = '0;
		unique case (mode_prev) inside
			MODE_INIT, MODE_PRECHARGE: begin
				if (cnt >= {1'b0, limit}) begin
					stepped = (mode_prev == MODE_INIT) ? MODE_IDLE : MODE_RUN;
				end else begin
					dwell_keep = cnt[DWELL_W-1:0];
				end
			end
			MODE_IDLE: begin
				contactor_next = 1'b0;
				if (item.start_req) begin
					stepped = MODE_PRECHARGE;
				end else if (item.charge_req) begin
					stepped = MODE_CHARGING;
				end else if (item.stop_req) begin
					stepped = MODE_SLEEP;
				end
			end
			MODE_RUN: begin
				contactor_next = 1'b1;
				if (item.stop_req) begin
					stepped = MODE_STOP;
				end
			end
			MODE_STOP, MODE_NFAULT, MODE_CHARGED: begin
				contactor_next = 1'b0;
				if (item.reset_req) begin
					stepped = MODE_IDLE;
				end
			end
			MODE_SLEEP: begin
				if (item.reset_req) begin
					stepped = MODE_IDLE;
				end
			end
			MODE_SFAULT: begin
				contactor_next = 1'b0;
			end
			MODE_CHARGING: begin
				contactor_next = 1'b1;
				if (item.pack_voltage_mv > full_charge_voltage) begin
					stepped = MODE_CHARGED;
				end
			end
			default: begin
				// unused codes fall back to idle
				contactor_next = 1'b0;
				stepped        = MODE_IDLE;
			end
		endcase
	end

	// measurements are ignored while sleeping; severe fault is never downgraded
	always_comb begin
		mode_next = stepped;
		if (mode_prev != MODE_SLEEP) begin
			if (fault.severe) begin
				mode_next = MODE_SFAULT;
			end else if (fault.normal && (stepped != MODE_SFAULT)) begin
				mode_next = MODE_NFAULT;
			end
		end
	end

	assign dwell_next = (mode_next != mode_prev) ? '0 : dwell_keep;

endmodule

// ----- rtl/battery_pack_mode_controller.sv -----
// top level of the battery pack mode controller: registers, handshakes and configuration
`timescale 1ns / 1ps

//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------
//  item      | item_valid / item_ready   | in_item_t: pins and measurements
//  result    | result_valid / result_ready | out_item_t: mode, contactor, change
//  config    | cfg_we                    | cfg_index, cfg_data
//
// one tick per cycle unless the result side stalls: an item waits in the input
// register, the mode step and limit compares run on it there and the result lands in
// the output register, raising result_valid, as the item leaves the input register.
// the input register refills while a result waits, so a stalled output holds
// at most two items. reset puts the mode in init, contactor open, dwell zero
// and all limits at their defaults.

module battery_pack_mode_controller
	import bpmc_pkg::*;
#(
	parameter int INIT_TICKS = INIT_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	limits_t            severe_lim_q;
	limits_t            normal_lim_q;
	logic [15:0]        full_volt_q;
	logic [DWELL_W-1:0] prech_ticks_q;

	// control state
	logic [MODE_W-1:0]  mode_q;
	logic               contactor_q;
	logic [DWELL_W-1:0] dwell_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// output register
	logic      result_valid_q;
	out_item_t result_q;

	// step results
	fault_t             fault;
	logic [MODE_W-1:0]  mode_next;
	logic               contactor_next;
	logic [DWELL_W-1:0] dwell_next;

	logic advance;

	// the stage moves on when the output register is free or being emptied
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			severe_lim_q.volt <= SEV_VOLT_RST;
			severe_lim_q.curr <= SEV_CURR_RST;
			severe_lim_q.temp <= SEV_TEMP_RST;
			normal_lim_q.volt <= NRM_VOLT_RST;
			normal_lim_q.curr <= NRM_CURR_RST;
			normal_lim_q.temp <= NRM_TEMP_RST;
			full_volt_q       <= FULL_VOLT_RST;
			prech_ticks_q     <= PRECH_TICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEV_VOLT:   severe_lim_q.volt <= cfg_data;
				REG_SEV_CURR:   severe_lim_q.curr <= cfg_data;
				REG_SEV_TEMP:   severe_lim_q.temp <= cfg_data[7:0];
				REG_NRM_VOLT:   normal_lim_q.volt <= cfg_data;
				REG_NRM_CURR:   normal_lim_q.curr <= cfg_data;
				REG_NRM_TEMP:   normal_lim_q.temp <= cfg_data[7:0];
				REG_FULL_VOLT:  full_volt_q       <= cfg_data;
				REG_PRECH_TICK: prech_ticks_q     <= cfg_data[DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	bpmc_fault_chk u_fault_chk (
		.item       (item_s1),
		.severe_lim (severe_lim_q),
		.normal_lim (normal_lim_q),
		.fault      (fault)
	);

	bpmc_mode_step #(
		.INIT_TICKS (INIT_TICKS)
	) u_mode_step (
		.mode_prev           (mode_q),
		.contactor_prev      (contactor_q),
		.dwell_prev          (dwell_q),
		.item                (item_s1),
		.fault               (fault),
		.full_charge_voltage (full_volt_q),
		.precharge_ticks     (prech_ticks_q),
		.mode_next           (mode_next),
		.contactor_next      (contactor_next),
		.dwell_next          (dwell_next)
	);

	// state moves only when a tick leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INIT;
			contactor_q <= 1'b0;
			dwell_q     <= '0;
		end else if (advance) begin
			mode_q      <= mode_next;
			contactor_q <= contactor_next;
			dwell_q     <= dwell_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.mode         <= mode_next;
			result_q.contactor_on <= contactor_next;
			result_q.mode_changed <= (mode_next != mode_q);
		end
	end

endmodule

// ----- test/pack_mode_checker.sv -----
// transfer monitor, mode predictor and result scoreboard for the battery pack mode controller
`timescale 1ns / 1ps

module pack_mode_checker
	import bpmc_pkg::*;
#(
	parameter int INIT_TICKS = INIT_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  in_item_t              item,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    ticks_in_flight
);

	// predicted pack state and register mirror
	logic [MODE_W-1:0]  pack_mode;
	logic               contactor;
	logic [DWELL_W-1:0] dwell;
	limits_t            severe_lim;
	limits_t            normal_lim;
	logic [15:0]        full_volt;
	logic [DWELL_W-1:0] prech_ticks;

	out_item_t expected_ticks[$];
	out_item_t want;

	task automatic report_mismatch(input string what, input int unsigned want_v,
			input int unsigned got_v);
		mismatches++;
		if (mismatches <= 25)
			$display("%0t ns: %s, expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	function automatic logic over_limit(input limits_t lim, input in_item_t t);
		return (t.pack_voltage_mv > lim.volt) ||
			($signed(t.pack_current_ma) > $signed(lim.curr)) ||
			($signed(t.pack_temp_c) > $signed(lim.temp));
	endfunction

	// one control tick: mode step from the held mode, then the fault override
	function automatic out_item_t predict_tick(input in_item_t t);
		logic [MODE_W-1:0]  was;
		logic [MODE_W-1:0]  nxt;
		logic [DWELL_W-1:0] held;
		int                 count;
		int                 goal;
		out_item_t          r;
		was = pack_mode;
		nxt = was;
		held = '0;
		case (was)
			MODE_INIT, MODE_PRECHARGE: begin
				count = int'(dwell) + 1;
				goal = (was == MODE_INIT) ? INIT_TICKS : int'(prech_ticks);
				if (count >= goal)
					nxt = (was == MODE_INIT) ? MODE_IDLE : MODE_RUN;
				else
					held = count[DWELL_W-1:0];
			end
			MODE_IDLE: begin
				contactor = 1'b0;
				if (t.start_req)
					nxt = MODE_PRECHARGE;
				else if (t.charge_req)
					nxt = MODE_CHARGING;
				else if (t.stop_req)
					nxt = MODE_SLEEP;
			end
			MODE_RUN: begin
				contactor = 1'b1;
				if (t.stop_req)
					nxt = MODE_STOP;
			end
			MODE_STOP, MODE_NFAULT, MODE_CHARGED: begin
				contactor = 1'b0;
				if (t.reset_req)
					nxt = MODE_IDLE;
			end
			MODE_SLEEP: begin
				if (t.reset_req)
					nxt = MODE_IDLE;
			end
			MODE_SFAULT: begin
				contactor = 1'b0;
			end
			MODE_CHARGING: begin
				contactor = 1'b1;
				if (t.pack_voltage_mv > full_volt)
					nxt = MODE_CHARGED;
			end
			default: begin
				contactor = 1'b0;
				nxt = MODE_IDLE;
			end
		endcase
		// measurements count everywhere except sleep
		if (was != MODE_SLEEP) begin
			if (over_limit(severe_lim, t))
				nxt = MODE_SFAULT;
			else if (over_limit(normal_lim, t) && nxt != MODE_SFAULT)
				nxt = MODE_NFAULT;
		end
		dwell = (nxt != was) ? '0 : held;
		pack_mode = nxt;
		r.mode = nxt;
		r.contactor_on = contactor;
		r.mode_changed = (nxt != was);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_mode = MODE_INIT;
			contactor = 1'b0;
			dwell = '0;
			severe_lim.volt = SEV_VOLT_RST;
			severe_lim.curr = SEV_CURR_RST;
			severe_lim.temp = SEV_TEMP_RST;
			normal_lim.volt = NRM_VOLT_RST;
			normal_lim.curr = NRM_CURR_RST;
			normal_lim.temp = NRM_TEMP_RST;
			full_volt = FULL_VOLT_RST;
			prech_ticks = PRECH_TICK_RST;
			expected_ticks.delete();
			ticks_in_flight <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEV_VOLT:   severe_lim.volt = cfg_data;
					REG_SEV_CURR:   severe_lim.curr = cfg_data;
					REG_SEV_TEMP:   severe_lim.temp = cfg_data[7:0];
					REG_NRM_VOLT:   normal_lim.volt = cfg_data;
					REG_NRM_CURR:   normal_lim.curr = cfg_data;
					REG_NRM_TEMP:   normal_lim.temp = cfg_data[7:0];
					REG_FULL_VOLT:  full_volt = cfg_data;
					REG_PRECH_TICK: prech_ticks = cfg_data[DWELL_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch("result with nothing pending, mode", 0, result.mode);
				end else begin
					want = expected_ticks.pop_front();
					if (result.mode !== want.mode)
						report_mismatch("mode", want.mode, result.mode);
					if (result.contactor_on !== want.contactor_on)
						report_mismatch("contactor_on", want.contactor_on, result.contactor_on);
					if (result.mode_changed !== want.mode_changed)
						report_mismatch("mode_changed", want.mode_changed, result.mode_changed);
				end
			end
			if (item_valid && item_ready)
				expected_ticks.push_back(predict_tick(item));
			ticks_in_flight <= expected_ticks.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
// stimulus and verdict for the battery pack mode controller testbench
`timescale 1ns / 1ps

module tb_top;
	import bpmc_pkg::*;

	localparam int INIT_TICKS  = INIT_TICKS_DEF;
	localparam int HOLD_CYCLES = 60;

	// request pin patterns, ordered start, charge, stop, reset
	localparam logic [3:0] P_NONE   = 4'b0000;
	localparam logic [3:0] P_START  = 4'b1000;
	localparam logic [3:0] P_CHARGE = 4'b0100;
	localparam logic [3:0] P_STOP   = 4'b0010;
	localparam logic [3:0] P_RESET  = 4'b0001;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int ticks_in_flight;

	// idling knobs for the sender and the receiver
	bit sender_gaps;
	bit receiver_stalls;
	bit hold_off;

	// limits as last written, used only to shape the measurements
	int sv_cap, sc_cap, st_cap, nv_cap, nc_cap, nt_cap;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	battery_pack_mode_controller #(
		.INIT_TICKS(INIT_TICKS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pack_mode_checker #(
		.INIT_TICKS(INIT_TICKS)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.ticks_in_flight(ticks_in_flight)
	);

	// hard stop in case a transfer never happens
	initial begin
		#4000000;
		$display("tb_top: FAIL");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				// block keeps two ticks, then item_ready must drop
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
				result_ready <= 1'b1;
			end else if (receiver_stalls && $urandom_range(7) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(15, 1)) @(negedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	function automatic int rand_span(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic in_item_t tick_of(input logic [3:0] pins, input logic [15:0] v,
			input logic [15:0] c, input logic [7:0] t);
		return {pins, v, c, t};
	endfunction

	function automatic logic [3:0] rand_pins();
		logic [3:0] p;
		for (int k = 0; k < 4; k++)
			p[k] = ($urandom_range(2) == 0);
		return p;
	endfunction

	// level 0 stays within both limits, 1 trips only the normal limit, 2 the severe one;
	// a level with no room under the current limits falls back to quiet values
	function automatic in_item_t make_tick(input logic [3:0] pins, input int level);
		int v, c, t;
		int pick;
		v = rand_span(0, (sv_cap < nv_cap) ? sv_cap : nv_cap);
		c = rand_span(-32768, (sc_cap < nc_cap) ? sc_cap : nc_cap);
		t = rand_span(-128, (st_cap < nt_cap) ? st_cap : nt_cap);
		pick = $urandom_range(2);
		if (level == 1) begin
			case (pick)
				0: if (nv_cap < sv_cap) v = rand_span(nv_cap + 1, sv_cap);
				1: if (nc_cap < sc_cap) c = rand_span(nc_cap + 1, sc_cap);
				default: if (nt_cap < st_cap) t = rand_span(nt_cap + 1, st_cap);
			endcase
		end else if (level == 2) begin
			case (pick)
				0: if (sv_cap < 65535) v = rand_span(sv_cap + 1, 65535);
				1: if (sc_cap < 32767) c = rand_span(sc_cap + 1, 32767);
				default: if (st_cap < 127) t = rand_span(st_cap + 1, 127);
			endcase
		end
		return tick_of(pins, 16'(v), 16'(c), 8'(t));
	endfunction

	// offer one tick and hold it until the transfer; returns at that rising edge
	task automatic send_item(input in_item_t t);
		int gap;
		gap = (sender_gaps && $urandom_range(3) == 0) ? $urandom_range(15, 1) : 0;
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= t;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_quiet(input logic [3:0] pins);
		send_item(make_tick(pins, 0));
	endtask

	// drop valid, then wait for every pending result plus the pipeline depth
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (ticks_in_flight == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// narrow registers get junk above their width, which must be dropped
	task automatic set_limits(input int sv, input int sc, input int st, input int nv,
			input int nc, input int nt, input int full, input int prech);
		write_reg(REG_SEV_VOLT, 16'(sv));
		write_reg(REG_SEV_CURR, 16'(sc));
		write_reg(REG_SEV_TEMP, 16'(st));
		write_reg(REG_NRM_VOLT, 16'(nv));
		write_reg(REG_NRM_CURR, 16'(nc));
		write_reg(REG_NRM_TEMP, 16'(nt));
		write_reg(REG_FULL_VOLT, 16'(full));
		write_reg(REG_PRECH_TICK, {4'($urandom_range(15)), 12'(prech)});
		sv_cap = sv;
		sc_cap = sc;
		st_cap = st;
		nv_cap = nv;
		nc_cap = nc;
		nt_cap = nt;
	endtask

	// random pins; over_pct and severe_pct set the share of ticks that trip the normal or severe limit
	task automatic random_ticks(input int count, input int over_pct, input int severe_pct);
		int roll;
		int level;
		repeat (count) begin
			roll = $urandom_range(99);
			level = (roll < severe_pct) ? 2 : (roll < severe_pct + over_pct) ? 1 : 0;
			send_item(make_tick(rand_pins(), level));
		end
	endtask

	// from any mode but init, precharge and severe fault: leave sleep, fault, clear
	task automatic go_idle();
		send_quiet(P_RESET);
		send_item(make_tick(P_NONE, 1));
		send_quiet(P_RESET);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SEV_VOLT;
		cfg_data = '0;
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		hold_off = 1'b0;
		sv_cap = 65535;
		sc_cap = 32767;
		st_cap = 127;
		nv_cap = 65535;
		nc_cap = 32767;
		nt_cap = 127;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// init ticks carry field extremes and pin mixes 0 through 14; default limits never trip
		for (int i = 0; i < INIT_TICKS; i++)
			send_item(tick_of(4'(i), (i % 2) ? 16'hFFFF : 16'h0000,
				(i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'h7FFF : 16'h0000,
				(i % 3 == 0) ? 8'h7F : (i % 3 == 1) ? 8'h80 : 8'h00));
		settle();

		// zero precharge count behaves as one tick
		set_limits(60000, 30000, 90, 50000, 20000, 60, 45000, 0);
		send_item(tick_of(P_START | P_CHARGE | P_STOP, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_STOP, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_RESET, 16'd1000, 16'd0, 8'd25));
		// charging ends only strictly above the full voltage
		send_item(tick_of(P_CHARGE | P_STOP, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd45000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd45001, 16'd0, 8'd25));
		send_item(tick_of(P_RESET, 16'd1000, 16'd0, 8'd25));
		// sleep ignores even severe measurements, including on the wake tick
		send_item(tick_of(P_STOP, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'hFFFF, 16'h7FFF, 8'h7F));
		send_item(tick_of(P_RESET, 16'hFFFF, 16'h0000, 8'h7F));
		// values equal to the normal limits are fine, one above faults
		send_item(tick_of(P_NONE, 16'd50000, 16'd20000, 8'd60));
		send_item(tick_of(P_NONE, 16'd1000, 16'd0, 8'd61));
		send_item(tick_of(P_START, 16'd1000, 16'd0, 8'd25));
		// reset steps to idle but the fault wins again
		send_item(tick_of(P_RESET, 16'd1000, 16'd20001, 8'd25));
		send_item(tick_of(P_RESET, 16'd1000, 16'd0, 8'd25));
		// fault out of run leaves the contactor closed for that one tick
		send_item(tick_of(P_START, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_NONE, 16'd50001, 16'd0, 8'd25));
		send_item(tick_of(P_RESET, 16'd1000, 16'd0, 8'd25));
		settle();

		// widest limits: every measurement value is legal
		set_limits(65535, 32767, 127, 65535, 32767, 127, 51600, 1);
		random_ticks(150, 0, 0);
		settle();

		// moderate limits with occasional normal faults
		set_limits(60000, 30000, 100, 52000, 25000, 70, 48000, 7);
		random_ticks(150, 6, 0);
		// long result stall while ticks keep coming, so the input side backs up
		hold_off = 1'b1;
		random_ticks(40, 6, 0);
		settle();
		random_ticks(150, 6, 0);
		settle();

		// tightest normal limits: only the minimum readings pass, charged unreachable
		set_limits(65535, 32767, 127, 0, -32768, -128, 0, 2);
		random_ticks(100, 50, 0);
		settle();

		// long precharge, counted out to the end
		set_limits(60000, 30000, 100, 52000, 25000, 70, 40000, 120);
		go_idle();
		send_quiet(P_START);
		repeat (120) send_quiet(rand_pins());
		random_ticks(30, 6, 0);
		settle();

		set_limits(60000, 30000, 100, 52000, 25000, 70, 65535, 3);
		random_ticks(100, 6, 0);
		hold_off = 1'b1;
		random_ticks(100, 6, 0);
		settle();

		// closing stretch runs at full rate on both sides
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		random_ticks(100, 6, 0);

		// severe fault latches, so it comes last
		go_idle();
		send_quiet(P_START);
		repeat (3) send_quiet(P_NONE);
		send_quiet(P_NONE);
		send_item(tick_of(P_NONE, 16'd60001, 16'd0, 8'd25));
		send_item(tick_of(P_RESET, 16'd1000, 16'd0, 8'd25));
		send_item(tick_of(P_RESET, 16'd55000, 16'd0, 8'd25));
		send_item(tick_of(P_START | P_CHARGE, 16'd1000, 16'd0, 8'd25));
		settle();
		set_limits(0, -32768, -128, 0, -32768, -128, 65535, 4095);
		random_ticks(80, 20, 20);
		settle();

		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
